@@ hdl/planar_to_chunky_converter_macros.svh @@
// ============================================================================
// Planar to chunky converter assertion macros
// Shared assertion forms, all clocked on clk and disabled while rst is high.
// ============================================================================
`ifndef PLANAR_TO_CHUNKY_CONVERTER_MACROS_SVH
`define PLANAR_TO_CHUNKY_CONVERTER_MACROS_SVH

// A condition that holds at every clock edge.
`define PTC_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds at the same edge as its cause.
`define PTC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds at the next edge after its cause.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ptc_pkg.sv @@
// ============================================================================
// Planar to chunky converter package
// Widths, register codes and the job format shared by all converter modules.
// ============================================================================
`default_nettype none

package ptc_pkg;

  // Field and port widths.
  localparam int BYTE_W      = 8;
  localparam int PIX_W       = 4;
  localparam int X_W         = 10;
  localparam int BPP_W       = 3;
  localparam int LINE_W      = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int OUT_DATA_W  = 16;

  // Geometry of the planar formats.
  localparam int PIX_PER_BYTE  = 8;
  localparam int PIX_PER_GROUP = 16;
  localparam int PLANE_WORD_W  = 16;
  localparam int MAX_PLANES    = 4;
  localparam int DEPTH_CAP     = (MAX_PLANES < PIX_W) ? MAX_PLANES : PIX_W;
  localparam int STORE_BITS    = 3;
  localparam int PLANES_W      = PIX_W * PLANE_WORD_W;

  // Defaults.
  localparam int DEF_MAX_LINE_PIXELS = 640;
  localparam int QUEUE_DEPTH         = 4;
  localparam logic [BPP_W-1:0]  BPP_RESET  = 3'd4;
  localparam logic [LINE_W-1:0] LINE_RESET = 10'd320;
  localparam logic              MODE_RESET = 1'b0;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BITS_PER_PIXEL  = 2'd0,
    REG_LINE_PIXELS     = 2'd1,
    REG_INTERLEAVE_MODE = 2'd2
  } cfg_reg_t;

  // One unit of work for the pixel serializer: 16 or 8 finished pixels.
  typedef struct packed {
    logic [PIX_PER_GROUP-1:0][PIX_W-1:0] pix;
    logic                                wide;
    logic [X_W-1:0]                      x_base;
    logic                                lend;
  } job_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic room;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

@@ hdl/ptc_front.sv @@
// ============================================================================
// Planar to chunky front end
// Holds the configuration, takes bytes, assembles plane words or updates the
// line store, and hands finished pixel jobs to the queue.
// ============================================================================
`default_nettype none
`include "planar_to_chunky_converter_macros.svh"

module ptc_front #(
  parameter int MAX_LINE_PIXELS = ptc_pkg::DEF_MAX_LINE_PIXELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ptc_pkg::BYTE_W-1:0]      s_tdata,
  input  ptc_pkg::q_status_t              q_stat,
  output logic                           push,
  output ptc_pkg::job_t                   push_job
);
  import ptc_pkg::*;

  localparam int GROUPS_MAX = MAX_LINE_PIXELS / PIX_PER_GROUP;
  localparam int ROWS       = GROUPS_MAX * 2;
  localparam int GI_W       = (GROUPS_MAX > 1) ? $clog2(GROUPS_MAX) : 1;
  localparam int RI_W       = $clog2(ROWS);
  localparam int GC_W       = $clog2(GROUPS_MAX + 1);
  localparam int RAW_G_W    = LINE_W - 4;
  localparam int CW         = ((GC_W > RAW_G_W) ? GC_W : RAW_G_W) + 2;
  localparam int ROW_W      = STORE_BITS * PIX_PER_BYTE;

  typedef enum logic [1:0] {
    KIND_GROUP = 2'd0,
    KIND_TOP   = 2'd1,
    KIND_LOWER = 2'd2
  } kind_t;

  // Configuration registers.
  logic [BPP_W-1:0]  bpp;
  logic [LINE_W-1:0] line_px;
  logic              mode;
  logic              cfg_hit;

  // Conversion state.
  logic [PLANES_W-1:0] plane_words;
  logic [2:0]          byte_cnt;
  logic [GI_W-1:0]     group_index;
  logic [RI_W-1:0]     row_idx;
  logic [1:0]          plane_idx;

  // Second stage: one accepted item waiting for its line store row.
  logic              b_valid;
  kind_t             b_kind;
  logic [BYTE_W-1:0] b_byte;
  logic [RI_W-1:0]   b_row;
  logic [1:0]        b_plane;
  logic [X_W-1:0]    b_xbase;
  logic              b_lend;

  // Line store: one row of eight 3-bit entries per input byte position.
  logic [ROW_W-1:0] store [ROWS];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;

  logic [BPP_W-1:0] depth;
  logic [CW-1:0]    g_raw;
  logic [CW-1:0]    groups;
  logic [CW-1:0]    row_bytes;
  logic [3:0]       cnt_inc;
  logic             group_done;
  logic [2:0]       byte_pos;
  logic             grp_lend;
  logic [RI_W-1:0]  rr;
  logic [1:0]       pp;
  logic             line_top;
  logic             row_done;
  logic             s_accept;
  logic [1:0]       dm1;

  assign cfg_ready = 1'b1;
  assign s_tready  = q_stat.room;
  assign s_accept  = s_tvalid && s_tready;

  // Only the listed registers restart the line.
  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_BITS_PER_PIXEL:  cfg_hit = cfg_valid;
      REG_LINE_PIXELS:     cfg_hit = cfg_valid;
      REG_INTERLEAVE_MODE: cfg_hit = cfg_valid;
      default:             cfg_hit = 1'b0;
    endcase
  end

  // Effective depth and line length after clamping.
  always_comb begin
    if (bpp == '0) begin
      depth = BPP_W'(1);
    end else if (bpp > BPP_W'(DEPTH_CAP)) begin
      depth = BPP_W'(DEPTH_CAP);
    end else begin
      depth = bpp;
    end
    g_raw = CW'(line_px[LINE_W-1:4]);
    if (g_raw == '0) begin
      groups = CW'(1);
    end else if (g_raw > CW'(GROUPS_MAX)) begin
      groups = CW'(GROUPS_MAX);
    end else begin
      groups = g_raw;
    end
    row_bytes = groups << 1;
  end

  // Word-interleaved bookkeeping.
  assign cnt_inc    = {1'b0, byte_cnt} + 4'd1;
  assign group_done = cnt_inc >= {depth, 1'b0};
  assign byte_pos   = {byte_cnt[2:1], ~byte_cnt[0]};
  assign grp_lend   = (CW'(group_index) + CW'(1)) >= groups;

  // Line-interleaved bookkeeping.
  assign rr       = (CW'(row_idx) >= row_bytes) ? '0 : row_idx;
  assign pp       = ({1'b0, plane_idx} >= depth) ? '0 : plane_idx;
  assign line_top = ({1'b0, pp} + 3'd1) >= depth;
  assign row_done = (CW'(rr) + CW'(1)) >= row_bytes;

  // Control and conversion state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bpp         <= BPP_RESET;
      line_px     <= LINE_RESET;
      mode        <= MODE_RESET;
      plane_words <= '0;
      byte_cnt    <= '0;
      group_index <= '0;
      row_idx     <= '0;
      plane_idx   <= '0;
      b_valid     <= 1'b0;
    end else begin
      b_valid <= s_accept && (mode || group_done);
      if (cfg_hit) begin
        case (cfg_reg_t'(cfg_index))
          REG_BITS_PER_PIXEL:  bpp     <= cfg_data[BPP_W-1:0];
          REG_LINE_PIXELS:     line_px <= cfg_data[LINE_W-1:0];
          REG_INTERLEAVE_MODE: mode    <= cfg_data[0];
          default:             mode    <= mode;
        endcase
        plane_words <= '0;
        byte_cnt    <= '0;
        group_index <= '0;
        row_idx     <= '0;
        plane_idx   <= '0;
      end else if (s_accept) begin
        if (mode) begin
          row_idx <= row_done ? '0 : rr + RI_W'(1);
          if (row_done) begin
            plane_idx <= line_top ? '0 : pp + 2'd1;
          end else begin
            plane_idx <= pp;
          end
        end else begin
          plane_words[8*byte_pos +: 8] <= s_tdata;
          if (group_done) begin
            byte_cnt    <= '0;
            group_index <= grp_lend ? '0 : group_index + GI_W'(1);
          end else begin
            byte_cnt <= cnt_inc[2:0];
          end
        end
      end
    end
  end

  // Payload of the second stage.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      b_byte  <= s_tdata;
      b_row   <= rr;
      b_plane <= pp;
      if (mode) begin
        b_kind  <= line_top ? KIND_TOP : KIND_LOWER;
        b_xbase <= X_W'({rr, 3'b000});
        b_lend  <= row_done;
      end else begin
        b_kind  <= KIND_GROUP;
        b_xbase <= X_W'({group_index, 4'b0000});
        b_lend  <= grp_lend;
      end
    end
  end

  // Line store: read at accept, lower planes written back in the following cycle.
  always_ff @(posedge clk) begin
    if (s_accept && mode) begin
      rd_row <= store[rr];
    end
    if (b_valid && b_kind == KIND_LOWER) begin
      store[b_row] <= wr_row;
    end
  end

  assign dm1 = 2'(depth - BPP_W'(1));

  // Build the pixel job or the new store row.
  always_comb begin
    logic       bit_v;
    logic [2:0] ent;
    logic [3:0] low;
    bit_v           = 1'b0;
    ent             = '0;
    low             = '0;
    push_job        = '0;
    wr_row          = '0;
    push_job.x_base = b_xbase;
    push_job.lend   = b_lend;
    push_job.wide   = (b_kind == KIND_GROUP);
    if (b_kind == KIND_GROUP) begin
      for (int j = 0; j < PIX_PER_GROUP; j++) begin
        for (int p = 0; p < PIX_W; p++) begin
          push_job.pix[j][p] = (p < int'(depth)) &&
                               plane_words[p*PLANE_WORD_W + PLANE_WORD_W - 1 - j];
        end
      end
    end else begin
      for (int i = 0; i < PIX_PER_BYTE; i++) begin
        bit_v = b_byte[PIX_PER_BYTE-1-i];
        ent   = rd_row[STORE_BITS*i +: STORE_BITS];
        low   = {1'b0, ent} & ((4'd1 << dm1) - 4'd1);
        push_job.pix[i] = low | (4'(bit_v) << dm1);
        if (b_plane == 2'd0) begin
          wr_row[STORE_BITS*i +: STORE_BITS] = 3'(bit_v);
        end else begin
          wr_row[STORE_BITS*i +: STORE_BITS] = ent | (3'(bit_v) << b_plane);
        end
      end
    end
  end

  assign push = b_valid && (b_kind != KIND_LOWER);

  // A store write never meets a read of the same row.
  `PTC_ASSERT_IMPLIES(a_store_hazard, s_accept && mode && b_valid && b_kind == KIND_LOWER, rr != b_row, "line store row read while its write is pending")
  // The queue always has a slot for a finished job.
  `PTC_ASSERT_IMPLIES(a_push_room, push, !q_stat.full, "job pushed into a full queue")
  // The byte count of a plane group stays inside the group.
  `PTC_ASSERT_HOLDS(a_group_count, cnt_inc <= {depth, 1'b0}, "plane group byte count out of range")

endmodule

`default_nettype wire

@@ hdl/ptc_queue.sv @@
// ============================================================================
// Planar to chunky job queue
// Short first-in first-out queue of pixel jobs between front and back end.
// ============================================================================
`default_nettype none
`include "planar_to_chunky_converter_macros.svh"

module ptc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ptc_pkg::job_t       push_job,
  input  logic               pop,
  output logic               q_valid,
  output ptc_pkg::job_t       q_job,
  output ptc_pkg::q_status_t  q_stat
);
  import ptc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_valid     = (count != '0);
  assign q_job       = slots[rd_ptr];
  assign q_stat.full = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.room = (count <= CNT_W'(QUEUE_DEPTH - 2));

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `PTC_ASSERT_HOLDS(a_count_range, count <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `PTC_ASSERT_IMPLIES(a_pop_empty, pop, count != '0, "job taken from an empty queue")
  `PTC_ASSERT_NEXT(a_push_count, push && !pop, count == $past(count) + CNT_W'(1), "queue count did not follow a push")

endmodule

`default_nettype wire

@@ hdl/ptc_back.sv @@
// ============================================================================
// Planar to chunky back end
// Takes pixel jobs from the queue and sends one pixel per cycle through an
// output register while the m_ port is not held by a low m_tready.
// ============================================================================
`default_nettype none

module ptc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  ptc_pkg::job_t                   q_job,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ptc_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import ptc_pkg::*;

  localparam int K_W = $clog2(PIX_PER_GROUP);

  job_t           cur;
  logic           cur_valid;
  logic [K_W-1:0] k;
  logic [K_W-1:0] last_k;
  logic           adv;
  logic           fin;
  logic [X_W-1:0] x;

  assign last_k = cur.wide ? K_W'(PIX_PER_GROUP - 1) : K_W'(PIX_PER_BYTE - 1);
  assign adv    = cur_valid && (!m_tvalid || m_tready);
  assign fin    = adv && (k == last_k);
  assign pop    = q_valid && (!cur_valid || fin);
  assign x      = cur.x_base + X_W'(k);

  // Job sequencing and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        k         <= '0;
      end else if (fin) begin
        cur_valid <= 1'b0;
      end else if (adv) begin
        k <= k + K_W'(1);
      end
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Current job and output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
    if (adv) begin
      m_tdata <= OUT_DATA_W'({x, cur.pix[k]});
      m_tuser <= (k == last_k);
      m_tlast <= (k == last_k) && cur.lend;
    end
  end

endmodule

`default_nettype wire

@@ hdl/planar_to_chunky_converter.sv @@
// ============================================================================
// Planar to chunky converter
// Turns raw bitplane image bytes into one color index per pixel.
// ============================================================================
// Bytes enter on the s_ stream one per cycle while the job queue has room; in
// word-interleaved mode every 2*depth bytes form a group of 16 pixels, and in
// line-interleaved mode the bytes of the lower plane rows go into a line store
// of MAX_LINE_PIXELS/8 rows (one per byte position, eight 3-bit entries each)
// while each byte of the top plane row yields 8 pixels. The line store needs
// no clearing pass: plane 0 rewrites each row before it is read. Pixels leave
// on the m_ stream at one per cycle while m_tready is high, from a serializer
// behind a 4-job queue, so the sustained rate is set by that output port: a
// word group yields 16 pixels, a top plane byte 8, a lower plane byte none.
// A job passes the second stage, the queue and the job and output registers.
// Configuration writes are taken at any time, in the cycle they arrive; those
// to defined registers restart the line; they are meant for an idle converter.
`default_nettype none

module planar_to_chunky_converter #(
  parameter int MAX_LINE_PIXELS = ptc_pkg::DEF_MAX_LINE_PIXELS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input bytes.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ptc_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] byte_in
  // Output pixels.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ptc_pkg::OUT_DATA_W-1:0]  m_tdata,   // [3:0] pixel_value, [13:4] pixel_x
  output logic                           m_tuser,   // [0] run_last
  output logic                           m_tlast    // line_end
);
  import ptc_pkg::*;

  logic      push;
  job_t      push_job;
  logic      pop;
  logic      q_valid;
  job_t      q_job;
  q_status_t q_stat;

  ptc_front #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  ptc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_stat  (q_stat)
  );

  ptc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

`default_nettype wire
